// ===== src/bct_pkg.sv =====
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types and constants of the Bezier curve tessellator.
// ----------------------------------------------------------------------------
package bct_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned CountW   = 6;
  localparam int unsigned ParamW   = 17;
  localparam int unsigned WeightW  = 33;
  localparam int unsigned PointW   = 20;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned NumCoord = 8;

  // Largest segment count; larger counts are clamped to it.
  localparam logic [CountW-1:0] MaxSegments = 6'd63;
  // One in Q1.16, held in the 17-bit curve parameter.
  localparam logic [ParamW-1:0] ParamOne = 17'h10000;
  localparam logic [ScaleW-1:0] ScaleReset = 16'd4096;

  // Coordinate slots of a curve, x and y interleaved.
  localparam int unsigned SlotStartX = 0;
  localparam int unsigned SlotStartY = 1;
  localparam int unsigned SlotCtrlAX = 2;
  localparam int unsigned SlotCtrlAY = 3;
  localparam int unsigned SlotCtrlBX = 4;
  localparam int unsigned SlotCtrlBY = 5;
  localparam int unsigned SlotEndX   = 6;
  localparam int unsigned SlotEndY   = 7;

  // Curve kinds.
  localparam logic KindQuad  = 1'b0;
  localparam logic KindCubic = 1'b1;

  // One point to evaluate, handed from the sequencer to the datapath.
  typedef struct packed {
    logic [ParamW-1:0]                 t;
    logic                              kind;
    logic                              last;
    logic [NumCoord-1:0][CoordW-1:0]   pts;
  } bct_point_req_t;

endpackage

// ===== src/bct_in_if.sv =====
// ----------------------------------------------------------------------------
// bct_in_if
// Curve request channel.
// ----------------------------------------------------------------------------
interface bct_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   func;
  logic signed [bct_pkg::CoordW-1:0]      start_x;
  logic signed [bct_pkg::CoordW-1:0]      start_y;
  logic signed [bct_pkg::CoordW-1:0]      ctrl_a_x;
  logic signed [bct_pkg::CoordW-1:0]      ctrl_a_y;
  logic signed [bct_pkg::CoordW-1:0]      ctrl_b_x;
  logic signed [bct_pkg::CoordW-1:0]      ctrl_b_y;
  logic signed [bct_pkg::CoordW-1:0]      end_x;
  logic signed [bct_pkg::CoordW-1:0]      end_y;
  logic [bct_pkg::CountW-1:0]             segment_count;

  modport source (output valid, func, start_x, start_y, ctrl_a_x, ctrl_a_y,
                  ctrl_b_x, ctrl_b_y, end_x, end_y, segment_count,
                  input ready);
  modport sink   (input valid, func, start_x, start_y, ctrl_a_x, ctrl_a_y,
                  ctrl_b_x, ctrl_b_y, end_x, end_y, segment_count,
                  output ready);
endinterface

// ===== src/bct_out_if.sv =====
// ----------------------------------------------------------------------------
// bct_out_if
// Curve point result channel.
// ----------------------------------------------------------------------------
interface bct_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bct_pkg::PointW-1:0]      point_x;
  logic signed [bct_pkg::PointW-1:0]      point_y;
  logic                                   last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

// ===== src/bct_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bct_cfg_if
// Scale register write channel.
// ----------------------------------------------------------------------------
interface bct_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bct_pkg::ScaleW-1:0]     scale_factor;

  modport source (output valid, scale_factor, input ready);
  modport sink   (input valid, scale_factor, output ready);
endinterface

// ===== src/bct_seq.sv =====
// ----------------------------------------------------------------------------
// bct_seq
// Curve sequencer: holds one curve, finds 65536/n with a bit-serial divider
// and steps the curve parameter t = floor(i*65536/n) one point per advance.
// ----------------------------------------------------------------------------
module bct_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  bct_in_if.sink                  in_req,
  input  logic                    adv,
  output logic                    pt_valid,
  output bct_pkg::bct_point_req_t pt
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_RUN  = 3'b100
  } seq_state_t;

  seq_state_t                                        state_r, state_nxt;
  logic                                              kind_r, kind_nxt;
  logic [bct_pkg::NumCoord-1:0][bct_pkg::CoordW-1:0] pts_r, pts_nxt;
  logic [bct_pkg::CountW-1:0]                        n_r, n_nxt;
  logic [bct_pkg::CountW-1:0]                        idx_r, idx_nxt;
  logic [bct_pkg::ParamW-1:0]                        quo_r, quo_nxt;
  logic [bct_pkg::CountW-1:0]                        drem_r, drem_nxt;
  logic [4:0]                                        dcnt_r, dcnt_nxt;
  logic [bct_pkg::ParamW-1:0]                        t_r, t_nxt;
  logic [bct_pkg::CountW-1:0]                        rem_r, rem_nxt;

  logic [bct_pkg::CountW-1:0] seg_clamped;
  logic [bct_pkg::CountW:0]   trial;
  logic [bct_pkg::CountW:0]   rem_sum;
  logic                       is_last;

  assign seg_clamped = (in_req.segment_count > bct_pkg::MaxSegments) ?
                       bct_pkg::MaxSegments : in_req.segment_count;
  assign trial   = {drem_r, (dcnt_r == 5'd16)};
  assign rem_sum = {1'b0, rem_r} + {1'b0, drem_r};
  assign is_last = (idx_r == n_r);

  assign in_req.ready = (state_r == ST_IDLE);
  assign pt_valid     = (state_r == ST_RUN);
  assign pt.t         = is_last ? bct_pkg::ParamOne : t_r;
  assign pt.kind      = kind_r;
  assign pt.last      = is_last;
  assign pt.pts       = pts_r;

  // Next-state logic: capture, divide (skipped for a zero count), then emit points.
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    pts_nxt   = pts_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    quo_nxt   = quo_r;
    drem_nxt  = drem_r;
    dcnt_nxt  = dcnt_r;
    t_nxt     = t_r;
    rem_nxt   = rem_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          kind_nxt = in_req.func;
          pts_nxt[bct_pkg::SlotStartX] = in_req.start_x;
          pts_nxt[bct_pkg::SlotStartY] = in_req.start_y;
          pts_nxt[bct_pkg::SlotCtrlAX] = in_req.ctrl_a_x;
          pts_nxt[bct_pkg::SlotCtrlAY] = in_req.ctrl_a_y;
          pts_nxt[bct_pkg::SlotCtrlBX] = in_req.ctrl_b_x;
          pts_nxt[bct_pkg::SlotCtrlBY] = in_req.ctrl_b_y;
          pts_nxt[bct_pkg::SlotEndX]   = in_req.end_x;
          pts_nxt[bct_pkg::SlotEndY]   = in_req.end_y;
          n_nxt    = seg_clamped;
          idx_nxt  = '0;
          t_nxt    = '0;
          rem_nxt  = '0;
          quo_nxt  = '0;
          drem_nxt = '0;
          dcnt_nxt = 5'd16;
          state_nxt = (seg_clamped == '0) ? ST_RUN : ST_DIV;
        end
      end
      ST_DIV: begin
        // One quotient bit of 65536 / n per cycle.
        if (trial >= {1'b0, n_r}) begin
          drem_nxt = bct_pkg::CountW'(trial - {1'b0, n_r});
          quo_nxt  = {quo_r[bct_pkg::ParamW-2:0], 1'b1};
        end else begin
          drem_nxt = trial[bct_pkg::CountW-1:0];
          quo_nxt  = {quo_r[bct_pkg::ParamW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - 5'd1;
        if (dcnt_r == '0) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // Step t by the quotient, carrying the remainder.
        if (adv) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + bct_pkg::CountW'(1);
            if (rem_sum >= {1'b0, n_r}) begin
              rem_nxt = bct_pkg::CountW'(rem_sum - {1'b0, n_r});
              t_nxt   = t_r + quo_r + bct_pkg::ParamW'(1);
            end else begin
              rem_nxt = rem_sum[bct_pkg::CountW-1:0];
              t_nxt   = t_r + quo_r;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Curve and stepping registers.
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    pts_r  <= pts_nxt;
    n_r    <= n_nxt;
    idx_r  <= idx_nxt;
    quo_r  <= quo_nxt;
    drem_r <= drem_nxt;
    dcnt_r <= dcnt_nxt;
    t_r    <= t_nxt;
    rem_r  <= rem_nxt;
  end

endmodule

// ===== src/bct_dp.sv =====
// ----------------------------------------------------------------------------
// bct_dp
// Point datapath: Bernstein weights, weighted sum, scale, round and saturate
// in seven register stages that advance together.
// ----------------------------------------------------------------------------
module bct_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pt_valid,
  input  bct_pkg::bct_point_req_t     pt,
  input  logic [bct_pkg::ScaleW-1:0]  scale,
  output logic                        adv,
  bct_out_if.source                   out_rsp
);

  localparam int unsigned WW    = bct_pkg::WeightW;
  localparam int unsigned ProdW = WW + 1 + bct_pkg::CoordW;
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned LoW   = 24;
  localparam int unsigned HiW   = SumW - LoW;
  localparam int unsigned TotW  = SumW + bct_pkg::ScaleW;
  localparam int unsigned MagW  = 24;

  typedef logic [bct_pkg::NumCoord-1:0][bct_pkg::CoordW-1:0] coords_t;

  // Stage 1: u, u*u, u*t, t*t.
  logic                        v1_r;
  logic [bct_pkg::ParamW-1:0]  t1_r, u1_r;
  logic [33:0]                 uu1_r, ut1_r, tt1_r;
  logic                        kind1_r, last1_r;
  coords_t                     pts1_r;
  // Stage 2: weights.
  logic                        v2_r, last2_r;
  logic [3:0][WW-1:0]          w2_r;
  coords_t                     pts2_r;
  // Stage 3: products.
  logic                        v3_r, last3_r;
  logic [1:0][3:0][ProdW-1:0]  p3_r;
  // Stage 4: sums.
  logic                        v4_r, last4_r;
  logic [1:0][SumW-1:0]        s4_r;
  // Stage 5: magnitudes.
  logic                        v5_r, last5_r;
  logic [1:0]                  neg5_r;
  logic [1:0][SumW-1:0]        m5_r;
  // Stage 6: scaled partial products.
  logic                        v6_r, last6_r;
  logic [1:0]                  neg6_r;
  logic [1:0][HiW+bct_pkg::ScaleW-1:0] ph6_r;
  logic [1:0][LoW+bct_pkg::ScaleW-1:0] pl6_r;
  // Output register.
  logic                        ov_r, olast_r;
  logic [1:0][bct_pkg::PointW-1:0] opt_r;

  logic [bct_pkg::ParamW-1:0]  u0;
  logic [3:0][WW-1:0]          w_quad, w_cub;
  logic [50:0]                 c0, c3, c1b, c2b;
  logic [52:0]                 c1, c2;
  logic [1:0][bct_pkg::PointW-1:0] res;

  assign adv = !ov_r || out_rsp.ready;
  assign u0  = bct_pkg::ParamOne - pt.t;

  // Weight forms of both curve kinds.
  always_comb begin
    c0  = 51'(uu1_r) * 51'(u1_r);
    c3  = 51'(tt1_r) * 51'(t1_r);
    c1b = 51'(uu1_r) * 51'(t1_r);
    c2b = 51'(ut1_r) * 51'(t1_r);
    c1  = {2'b00, c1b} + {1'b0, c1b, 1'b0};
    c2  = {2'b00, c2b} + {1'b0, c2b, 1'b0};
    w_cub[0]  = c0[16 +: WW];
    w_cub[1]  = c1[16 +: WW];
    w_cub[2]  = c2[16 +: WW];
    w_cub[3]  = c3[16 +: WW];
    w_quad[0] = uu1_r[WW-1:0];
    w_quad[1] = {ut1_r[WW-2:0], 1'b0};
    w_quad[2] = '0;
    w_quad[3] = tt1_r[WW-1:0];
  end

  // Final rounding and saturation to Q16.4.
  always_comb begin
    logic [TotW-1:0] tot;
    logic [MagW-1:0] r;
    for (int a = 0; a < 2; a++) begin
      tot = (TotW'(ph6_r[a]) << LoW) + TotW'(pl6_r[a]) + (TotW'(1) << 43);
      r   = tot[44 +: MagW];
      if (!neg6_r[a] && r > MagW'(524287)) begin
        r = MagW'(524287);
      end
      if (neg6_r[a] && r > MagW'(524288)) begin
        r = MagW'(524288);
      end
      res[a] = neg6_r[a] ? bct_pkg::PointW'(-r) : r[bct_pkg::PointW-1:0];
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v1_r <= pt_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      ov_r <= v6_r;
    end
  end

  // Payload of the stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r    <= pt.t;
      u1_r    <= u0;
      uu1_r   <= 34'(u0) * 34'(u0);
      ut1_r   <= 34'(u0) * 34'(pt.t);
      tt1_r   <= 34'(pt.t) * 34'(pt.t);
      kind1_r <= pt.kind;
      last1_r <= pt.last;
      pts1_r  <= pt.pts;

      w2_r    <= (kind1_r == bct_pkg::KindCubic) ? w_cub : w_quad;
      last2_r <= last1_r;
      pts2_r  <= pts1_r;

      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < 4; k++) begin
          p3_r[a][k] <= ProdW'($signed({1'b0, w2_r[k]})) *
                        ProdW'($signed(pts2_r[2*k+a]));
        end
      end
      last3_r <= last2_r;

      for (int a = 0; a < 2; a++) begin
        s4_r[a] <= SumW'($signed(p3_r[a][0])) + SumW'($signed(p3_r[a][1])) +
                   SumW'($signed(p3_r[a][2])) + SumW'($signed(p3_r[a][3]));
      end
      last4_r <= last3_r;

      for (int a = 0; a < 2; a++) begin
        neg5_r[a] <= s4_r[a][SumW-1];
        m5_r[a]   <= s4_r[a][SumW-1] ? -s4_r[a] : s4_r[a];
      end
      last5_r <= last4_r;

      for (int a = 0; a < 2; a++) begin
        ph6_r[a] <= (HiW+bct_pkg::ScaleW)'(m5_r[a][SumW-1:LoW]) *
                    (HiW+bct_pkg::ScaleW)'(scale);
        pl6_r[a] <= (LoW+bct_pkg::ScaleW)'(m5_r[a][LoW-1:0]) *
                    (LoW+bct_pkg::ScaleW)'(scale);
      end
      neg6_r  <= neg5_r;
      last6_r <= last5_r;

      opt_r   <= res;
      olast_r <= last6_r;
    end
  end

  assign out_rsp.valid      = ov_r;
  assign out_rsp.point_x    = opt_r[0];
  assign out_rsp.point_y    = opt_r[1];
  assign out_rsp.last_point = olast_r;

endmodule

// ===== src/bezier_curve_tessellator.sv =====
// Timing: an accepted curve request first runs the bit-serial 65536/n divider;
//   each point then passes the 7 register stages of the datapath. A zero count
//   skips the divide and yields a single point. The sequencer hands on one
//   point per cycle while the datapath is not stalled by out_rsp.ready, and
//   takes a new curve only once it has handed on the last point of the current
//   one. Reset: synchronous active-low rst_n empties the pipeline, idles the
//   sequencer and sets the scale register to 1.0 (4096).
// ----------------------------------------------------------------------------
// bezier_curve_tessellator
// Uniform tessellation of quadratic and cubic Bezier curves into scaled,
// rounded and saturated Q16.4 points.
// ----------------------------------------------------------------------------
module bezier_curve_tessellator (
  input  logic       clk,
  input  logic       rst_n,
  bct_in_if.sink     in_req,
  bct_out_if.source  out_rsp,
  bct_cfg_if.sink    cfg_req
);

  logic [bct_pkg::ScaleW-1:0] scale_r;
  logic                       adv;
  logic                       pt_valid;
  bct_pkg::bct_point_req_t    pt;

  assign cfg_req.ready = 1'b1;

  // Scale register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= bct_pkg::ScaleReset;
    end else if (cfg_req.valid) begin
      scale_r <= cfg_req.scale_factor;
    end
  end

  bct_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .adv      (adv),
    .pt_valid (pt_valid),
    .pt       (pt)
  );

  bct_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .pt_valid (pt_valid),
    .pt       (pt),
    .scale    (scale_r),
    .adv      (adv),
    .out_rsp  (out_rsp)
  );

endmodule
